// ----- rtl/core/lbbs_pkg.sv -----
// ----------------------------------------------------------------------------
// lbbs_pkg
// Shared types and constants of the lcg / bbs byte stream generator.
// ----------------------------------------------------------------------------
package lbbs_pkg;

	localparam int WORD_W  = 32;
	localparam int CNT_W   = 5;
	localparam int OP_W    = 2;
	localparam int IDX_W   = 2;
	localparam int BYTE_W  = 8;
	localparam int SHIFT   = 24;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [BYTE_W-1:0] byte_t;

	localparam op_t OP_LCG  = 2'd0;
	localparam op_t OP_BBS  = 2'd1;
	localparam op_t OP_HOLD = 2'd2;

	localparam idx_t REG_MULT_A    = 2'd0;
	localparam idx_t REG_INCR_C    = 2'd1;
	localparam idx_t REG_MODULUS_M = 2'd2;

	localparam word_t MULT_A_RST    = 32'd1664525;
	localparam word_t INCR_C_RST    = 32'd1013904223;
	localparam word_t MODULUS_M_RST = 32'd0;

endpackage

// ----- rtl/core/lbbs_if.sv -----
// ----------------------------------------------------------------------------
// lbbs interfaces
// Request, response and register write channels of the generator.
// ----------------------------------------------------------------------------
interface lbbs_req_if import lbbs_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  reload;
	word_t seed_value;
	op_t   op;
	modport source (output valid, reload, seed_value, op, input ready);
	modport sink (input valid, reload, seed_value, op, output ready);
endinterface

interface lbbs_rsp_if import lbbs_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t random_byte;
	modport source (output valid, random_byte, input ready);
	modport sink (input valid, random_byte, output ready);
endinterface

interface lbbs_cfg_if import lbbs_pkg::*; ();
	logic  valid;
	logic  ready;
	idx_t  index;
	word_t data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/lbbs_mul.sv -----
// ----------------------------------------------------------------------------
// lbbs_mul
// Bit-serial multiplier, low 32 bits of the product, one multiplier bit
// per cycle, msb first.
// ----------------------------------------------------------------------------
module lbbs_mul import lbbs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t mcand,
	input  word_t mplier,
	output logic  done,
	output word_t product
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            mcand_q;
	word_t            mplier_q;
	word_t            acc_q;
	word_t            acc_next;

	assign acc_next = {acc_q[WORD_W-2:0], 1'b0} + (mplier_q[WORD_W-1] ? mcand_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= acc_next;
			mplier_q <= {mplier_q[WORD_W-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ----- rtl/core/lbbs_mod.sv -----
// ----------------------------------------------------------------------------
// lbbs_mod
// Bit-serial restoring remainder, one dividend bit per cycle, msb first.
// ----------------------------------------------------------------------------
module lbbs_mod import lbbs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t dividend,
	input  word_t modulus,
	output logic  done,
	output word_t remainder
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            dvd_q;
	word_t            mod_q;
	word_t            rem_q;
	logic [WORD_W:0]  trial;
	logic [WORD_W:0]  diff;

	assign trial = {rem_q, dvd_q[WORD_W-1]};
	assign diff  = trial - {1'b0, mod_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			mod_q <= modulus;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/core/lcg_bbs_byte_stream_prng.sv -----
// ----------------------------------------------------------------------------
// lcg_bbs_byte_stream_prng
// Byte stream generator: lcg or squaring step, or hold, on a 32-bit state,
// reduced by a programmable modulus if nonzero, top byte returned per request.
//
//   channel  dir  word
//   req      in   reload, seed_value, op
//   rsp      out  random_byte
//   cfg      in   index, data (always ready)
//
// lcg / bbs step: the bit-serial multiplier, then the bit-serial remainder
// unit when the modulus is nonzero. hold skips both units.
// one word in flight; req.ready is high only while idle.
// the result sits in an output register until taken, the next word is
// accepted meanwhile; reset clears the state to zero, registers to defaults.
// ----------------------------------------------------------------------------
module lcg_bbs_byte_stream_prng import lbbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lbbs_req_if.sink   req,
	lbbs_rsp_if.source rsp,
	lbbs_cfg_if.sink   cfg
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_MOD  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	word_t      mult_a_q;
	word_t      incr_c_q;
	word_t      modulus_m_q;
	word_t      gen_state_q;
	word_t      res_q;
	logic       lcg_q;
	logic       out_valid_q;
	byte_t      out_byte_q;

	logic  accept;
	logic  is_step;
	word_t x_in;
	word_t mcand;
	logic  mul_done;
	word_t product;
	word_t sum;
	logic  mod_start;
	logic  mod_done;
	word_t remainder;
	logic  out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign x_in      = req.reload ? req.seed_value : gen_state_q;
	assign is_step   = (req.op == OP_LCG) || (req.op == OP_BBS);
	assign mcand     = (req.op == OP_LCG) ? mult_a_q : x_in;
	assign sum       = product + (lcg_q ? incr_c_q : '0);
	assign mod_start = mul_done && (modulus_m_q != '0);
	assign out_free  = !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	lbbs_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && is_step),
		.mcand   (mcand),
		.mplier  (x_in),
		.done    (mul_done),
		.product (product)
	);

	lbbs_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (sum),
		.modulus   (modulus_m_q),
		.done      (mod_done),
		.remainder (remainder)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mult_a_q    <= MULT_A_RST;
			incr_c_q    <= INCR_C_RST;
			modulus_m_q <= MODULUS_M_RST;
			gen_state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_MULT_A:    mult_a_q    <= cfg.data;
					REG_INCR_C:    incr_c_q    <= cfg.data;
					REG_MODULUS_M: modulus_m_q <= cfg.data;
					default:       ;
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= is_step ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= mod_start ? ST_MOD : ST_DONE;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						gen_state_q <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lcg_q <= (req.op == OP_LCG);
			res_q <= x_in;
		end else if (state_q == ST_MUL && mul_done) begin
			res_q <= sum;
		end else if (state_q == ST_MOD && mod_done) begin
			res_q <= remainder;
		end
		if (state_q == ST_DONE && out_free) begin
			out_byte_q <= res_q[SHIFT +: BYTE_W];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.random_byte = out_byte_q;

`ifndef NO_ASSERTIONS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MUL || state_q == ST_DONE))
		else $error("accepted word did not start work");
	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MUL))
		else $error("multiplier finished outside multiply phase");
	a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_MOD))
		else $error("remainder unit finished outside reduce phase");
	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (rsp.valid && state_q == ST_IDLE))
		else $error("result not presented");
`endif

endmodule

// ----- test/tb_lcg_bbs_byte_stream_prng.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcg_bbs_byte_stream_prng
// Self-checking bench for the lcg / bbs byte stream generator. A directed
// table covers reset state, field extremes, every op, hold with reload, the
// zero modulus and the undefined op, and then several register settings get
// random request streams. Every returned byte is checked in order against a
// state predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_lcg_bbs_byte_stream_prng;
	import lbbs_pkg::*;

	localparam op_t OP_UNDEF   = 2'd3;
	localparam int  N_DIR      = 26;
	localparam int  N_PHASE    = 10;
	localparam int  PHASE_WORDS = 188;
	localparam int  MAX_SHOWN  = 10;
	localparam int  LONG_HOLD  = 400;

	typedef struct packed {
		logic  is_cfg;
		idx_t  index;
		word_t data;
		logic  reload;
		word_t seed;
		op_t   op;
		logic  has_exp;
		byte_t exp_byte;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	lbbs_req_if req_if ();
	lbbs_rsp_if rsp_if ();
	lbbs_cfg_if cfg_if ();

	lcg_bbs_byte_stream_prng u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	word_t    cfg_mult;
	word_t    cfg_incr;
	word_t    cfg_mod;
	word_t    model_state;
	byte_t    expected_bytes [$];
	int       err_count = 0;
	int       rcv_count = 0;
	bit       send_no_gap = 1'b0;
	dir_row_t dir_rows [N_DIR];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic word_t apply_modulus(word_t v);
		return (cfg_mod == '0) ? v : v % cfg_mod;
	endfunction

	function automatic word_t advance_state(word_t cur, logic reload, word_t seed, op_t op);
		word_t s;
		s = reload ? seed : cur;
		case (op)
			OP_LCG: s = apply_modulus(cfg_mult * s + cfg_incr);
			OP_BBS: s = apply_modulus(s * s);
			default: ;
		endcase
		return s;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 16);
		else
			return $urandom_range(40, 150);
	endfunction

	function automatic word_t pick_seed();
		int r;
		r = $urandom_range(0, 15);
		case (r)
			0: return '0;
			1: return '1;
			2: return word_t'(1) << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t pick_op();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return OP_LCG;
		else if (r < 7)
			return OP_BBS;
		else if (r < 9)
			return OP_HOLD;
		else
			return OP_UNDEF;
	endfunction

	function automatic dir_row_t mk_item(logic reload, word_t seed, op_t op, logic has_exp,
			byte_t exp_byte);
		dir_row_t r;
		r = '0;
		r.reload = reload;
		r.seed = seed;
		r.op = op;
		r.has_exp = has_exp;
		r.exp_byte = exp_byte;
		return r;
	endfunction

	function automatic dir_row_t mk_cfg(idx_t index, word_t data);
		dir_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.index = index;
		r.data = data;
		return r;
	endfunction

	task automatic send_word(logic reload, word_t seed, op_t op, logic has_exp, byte_t exp_byte);
		int gap;
		word_t nxt;
		gap = send_no_gap ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.reload = reload;
		req_if.seed_value = seed;
		req_if.op = op;
		forever begin
			@(posedge clk);
			if (req_if.ready === 1'b1)
				break;
		end
		nxt = advance_state(model_state, reload, seed, op);
		model_state = nxt;
		expected_bytes.push_back(has_exp ? exp_byte : nxt[SHIFT +: BYTE_W]);
	endtask

	task automatic drain_all();
		@(negedge clk);
		req_if.valid = 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(idx_t index, word_t data);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = index;
		cfg_if.data = data;
		forever begin
			@(posedge clk);
			if (cfg_if.ready === 1'b1)
				break;
		end
		case (index)
			REG_MULT_A: cfg_mult = data;
			REG_INCR_C: cfg_incr = data;
			REG_MODULUS_M: cfg_mod = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	initial begin
		dir_rows[0]  = mk_item(1'b0, '0, OP_HOLD, 1'b1, 8'h00);
		dir_rows[1]  = mk_item(1'b0, '0, OP_LCG, 1'b1, 8'h3c);
		dir_rows[2]  = mk_item(1'b0, '0, OP_LCG, 1'b0, '0);
		dir_rows[3]  = mk_item(1'b0, '0, OP_BBS, 1'b0, '0);
		dir_rows[4]  = mk_item(1'b1, 32'hffff_ffff, OP_HOLD, 1'b1, 8'hff);
		dir_rows[5]  = mk_item(1'b1, 32'hffff_ffff, OP_BBS, 1'b1, 8'h00);
		dir_rows[6]  = mk_item(1'b0, 32'h0000_0000, OP_UNDEF, 1'b1, 8'h00);
		dir_rows[7]  = mk_item(1'b1, 32'h8000_0000, OP_UNDEF, 1'b1, 8'h80);
		dir_rows[8]  = mk_item(1'b1, 32'h8000_0000, OP_BBS, 1'b1, 8'h00);
		dir_rows[9]  = mk_item(1'b1, 32'hffff_ffff, OP_LCG, 1'b0, '0);
		dir_rows[10] = mk_item(1'b0, 32'hffff_ffff, OP_HOLD, 1'b0, '0);
		dir_rows[11] = mk_cfg(REG_MODULUS_M, 32'd1);
		dir_rows[12] = mk_item(1'b1, 32'hffff_ffff, OP_LCG, 1'b1, 8'h00);
		dir_rows[13] = mk_item(1'b1, 32'hffff_ffff, OP_HOLD, 1'b1, 8'hff);
		dir_rows[14] = mk_item(1'b0, 32'h0000_0000, OP_BBS, 1'b1, 8'h00);
		dir_rows[15] = mk_cfg(REG_MULT_A, 32'hffff_ffff);
		dir_rows[16] = mk_cfg(REG_INCR_C, 32'hffff_ffff);
		dir_rows[17] = mk_cfg(REG_MODULUS_M, 32'hffff_ffff);
		dir_rows[18] = mk_item(1'b1, 32'h0000_0000, OP_LCG, 1'b1, 8'h00);
		dir_rows[19] = mk_item(1'b1, 32'hffff_fffe, OP_BBS, 1'b0, '0);
		dir_rows[20] = mk_item(1'b1, 32'h1234_5678, OP_LCG, 1'b0, '0);
		dir_rows[21] = mk_cfg(REG_MODULUS_M, 32'd0);
		dir_rows[22] = mk_cfg(REG_MULT_A, 32'd0);
		dir_rows[23] = mk_cfg(REG_INCR_C, 32'd0);
		dir_rows[24] = mk_item(1'b1, 32'hdead_beef, OP_LCG, 1'b1, 8'h00);
		dir_rows[25] = mk_item(1'b1, 32'hffff_ffff, OP_BBS, 1'b1, 8'h00);

		cfg_mult = MULT_A_RST;
		cfg_incr = INCR_C_RST;
		cfg_mod = MODULUS_M_RST;
		model_state = '0;

		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.reload = 1'b0;
		req_if.seed_value = '0;
		req_if.op = OP_LCG;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_MULT_A;
		cfg_if.data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].is_cfg) begin
				drain_all();
				write_reg(dir_rows[i].index, dir_rows[i].data);
			end else begin
				send_word(dir_rows[i].reload, dir_rows[i].seed, dir_rows[i].op,
					dir_rows[i].has_exp, dir_rows[i].exp_byte);
			end
		end

		for (int p = 0; p < N_PHASE; p++) begin
			word_t a, c, m;
			case (p)
				0: begin
					a = MULT_A_RST;
					c = INCR_C_RST;
					m = MODULUS_M_RST;
				end
				1: begin
					a = '1;
					c = '1;
					m = '1;
				end
				2: begin
					a = '0;
					c = '0;
					m = 32'd1;
				end
				3: begin
					a = $urandom | 32'd1;
					c = $urandom;
					m = '0;
				end
				4: begin
					a = $urandom;
					c = $urandom;
					m = $urandom | 32'h8000_0000;
				end
				5: begin
					a = $urandom;
					c = $urandom;
					m = $urandom_range(1, 1000);
				end
				6: begin
					a = 32'd1;
					c = '0;
					m = '0;
				end
				7: begin
					a = $urandom;
					c = $urandom;
					m = 32'h8000_0000;
				end
				8: begin
					a = $urandom;
					c = $urandom;
					m = $urandom;
				end
				default: begin
					a = $urandom;
					c = '0;
					m = '1;
				end
			endcase
			drain_all();
			write_reg(REG_MULT_A, a);
			write_reg(REG_INCR_C, c);
			write_reg(REG_MODULUS_M, m);
			send_no_gap = (p == 2 || p == 6);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (p == 4 && k == PHASE_WORDS / 2)
					drain_all();
				send_word($urandom_range(0, 7) == 0, pick_seed(), pick_op(), 1'b0, '0);
			end
		end

		drain_all();
		repeat (100) @(posedge clk);
		if (err_count == 0 && expected_bytes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int    stall_left;
		int    hold_left;
		byte_t want;
		stall_left = 0;
		hold_left = 0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_if.ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp_if.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_if.ready = 1'b1;
			end
			@(posedge clk);
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
				rcv_count++;
				if (expected_bytes.size() == 0) begin
					if (err_count < MAX_SHOWN)
						$display("%0t: unexpected word, random_byte %h", $realtime,
							rsp_if.random_byte);
					err_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (rsp_if.random_byte !== want) begin
						if (err_count < MAX_SHOWN)
							$display("%0t: random_byte mismatch, expected %h got %h",
								$realtime, want, rsp_if.random_byte);
						err_count++;
					end
				end
				// long hold lets the request side back up against a full block
				if (rcv_count == 600 || rcv_count == 1300)
					hold_left = LONG_HOLD;
				else if ((rcv_count / 150) % 4 != 1)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
